@@ hdl/clpa_pkg.sv @@
`default_nettype none
package clpa_pkg;

    localparam int MAX_ROWS   = 4096;
    localparam int MAX_WEIGHT = 11;

    // derived widths
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CNT_W  = ROW_W + 1;
    localparam int TAP_W  = $clog2(MAX_WEIGHT);
    localparam int TCNT_W = $clog2(MAX_WEIGHT + 1);

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int TIDX_W    = 4;
    localparam int POS_W     = 12;
    localparam int CFG_W     = 13;
    localparam int WGT_W     = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TAP = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_MESSAGE  = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'd1;

endpackage
`default_nettype wire

@@ hdl/clpa_mod.sv @@
`default_nettype none
module clpa_mod
    import clpa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [POS_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [ROW_W-1:0]      o_rem
);

    localparam int STEP_W = $clog2(POS_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [ROW_W-1:0]  r_rem;
    logic [CNT_W-1:0]  n_trial;
    logic [CNT_W-1:0]  n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_dvd[POS_W-1]};
        if (n_trial >= r_dvs) begin
            n_rem = n_trial - r_dvs;
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == STEP_W'(POS_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= ROW_W'(n_rem);
                r_dvd  <= {r_dvd[POS_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(POS_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ hdl/circulant_ldpc_parity_accumulator.sv @@
`default_nettype none
// tap loads, parity writes and past-end or zero message bits finish in the idle state
// message bit one: one read-modify-write per tap per cycle, after the serial modulo unit has
// recomputed each tap whose reduced offset is stale (after its offset was loaded, or after
// the row count changed)
// one item at a time; busy is high from acceptance to the result strobe, except for those items
// reset: synchronous; every row of the parity ram is then cleared with busy high
module circulant_ldpc_parity_accumulator
    import clpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [TIDX_W-1:0]    i_tap_index,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic                 i_bit_value,
    input  wire logic                 i_restart,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    output logic                      o_read_bit,
    output logic                      o_status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RED,
        S_DIV,
        S_TAPS
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_rows;
    logic [WGT_W-1:0] r_weight;

    logic [POS_W-1:0] r_tap_start [MAX_WEIGHT];
    logic [ROW_W-1:0] r_tap_red   [MAX_WEIGHT];
    logic [MAX_WEIGHT-1:0] r_red_ok;
    logic [CNT_W-1:0] r_red_rows;

    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_col_cur;
    logic [TCNT_W-1:0] r_j;
    logic [TAP_W-1:0]  r_div_tap;
    logic [ROW_W-1:0]  r_clr_addr;
    logic              r_pos_ok;

    // write stage of the tap pipeline, and the last write for forwarding
    logic             r_p_vld;
    logic [ROW_W-1:0] r_p_addr;
    logic             r_last_we;
    logic [ROW_W-1:0] r_last_addr;
    logic             r_last_data;

    logic             r_mem [MAX_ROWS];
    logic             r_rdata;
    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    logic             mem_wdata;
    logic [ROW_W-1:0] mem_raddr;

    logic [CNT_W-1:0]      rows_eff;
    logic [TCNT_W-1:0]     weight_eff;
    logic                  accept;
    t_cmd                  cmd;
    logic                  pos_in_range;
    logic [CNT_W-1:0]      n_col;
    logic [MAX_WEIGHT-1:0] pend;
    logic                  pend_any;
    logic [TAP_W-1:0]      pend_first;
    logic                  issue;
    logic [TAP_W-1:0]      tap_sel;
    logic [CNT_W:0]        n_sum;
    logic [ROW_W-1:0]      n_row;
    logic                  rd_eff;
    logic                  div_start;
    logic                  div_done;
    logic [ROW_W-1:0]      div_rem;
    logic                  n_valid;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign cmd    = t_cmd'(i_command);

    assign pos_in_range = (32'(i_position) < MAX_ROWS);
    assign n_col        = i_restart ? '0 : r_col;

    always_comb begin
        if (r_rows == '0) begin
            rows_eff = CNT_W'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            rows_eff = CNT_W'(MAX_ROWS);
        end else begin
            rows_eff = CNT_W'(r_rows);
        end
        if (32'(r_weight) > MAX_WEIGHT) begin
            weight_eff = TCNT_W'(MAX_WEIGHT);
        end else begin
            weight_eff = TCNT_W'(r_weight);
        end
    end

    // taps in use whose reduced offset is stale
    always_comb begin
        pend_first = '0;
        for (int j = 0; j < MAX_WEIGHT; j++) begin
            pend[j] = !r_red_ok[j] && (TCNT_W'(j) < weight_eff);
        end
        for (int j = MAX_WEIGHT - 1; j >= 0; j--) begin
            if (pend[j]) begin
                pend_first = TAP_W'(j);
            end
        end
        pend_any = |pend;
    end

    assign div_start = (r_state == S_RED) && pend_any;

    clpa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tap_start[pend_first]),
        .i_divisor  (rows_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // row of the current tap: reduced offset plus column, wrapped once
    always_comb begin
        issue   = (r_j < weight_eff);
        tap_sel = (32'(r_j) < MAX_WEIGHT) ? TAP_W'(r_j) : '0;
        n_sum   = (CNT_W+1)'(r_tap_red[tap_sel]) + (CNT_W+1)'(r_col_cur);
        if (n_sum >= (CNT_W+1)'(rows_eff)) begin
            n_row = ROW_W'(n_sum - (CNT_W+1)'(rows_eff));
        end else begin
            n_row = ROW_W'(n_sum);
        end
        // a read that met a write to the same row at the same edge saw the old bit
        if (r_last_we && (r_last_addr == r_p_addr)) begin
            rd_eff = r_last_data;
        end else begin
            rd_eff = r_rdata;
        end
    end

    // result strobe for the next cycle
    always_comb begin
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid = (cmd != CMD_READ)
                        && !((cmd == CMD_MESSAGE) && (n_col < rows_eff) && i_bit_value);
                end
            end
            S_READ: begin
                n_valid = 1'b1;
            end
            S_TAPS: begin
                n_valid = !issue && !r_p_vld;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p_addr;
        mem_wdata = !rd_eff;
        mem_raddr = ROW_W'(i_position);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = 1'b0;
            end
            S_IDLE: begin
                if (accept && (cmd == CMD_WRITE) && pos_in_range) begin
                    mem_we    = 1'b1;
                    mem_waddr = ROW_W'(i_position);
                    mem_wdata = i_bit_value;
                end
            end
            S_TAPS: begin
                mem_we    = r_p_vld;
                mem_raddr = n_row;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= CFG_W'(MAX_ROWS);
            r_weight <= WGT_W'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS:   r_rows   <= i_cfg_data;
                CFG_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_we   <= mem_we;
        r_last_addr <= mem_waddr;
        r_last_data <= mem_wdata;
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_col      <= '0;
            r_red_ok   <= '0;
            r_red_rows <= '0;
            r_j        <= '0;
            r_p_vld    <= 1'b0;
            o_valid    <= 1'b0;
            o_read_bit <= 1'b0;
            o_status   <= 1'b0;
            for (int j = 0; j < MAX_WEIGHT; j++) begin
                r_tap_start[j] <= '0;
            end
        end else begin
            o_valid <= n_valid;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ROW_W'(MAX_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        o_read_bit <= 1'b0;
                        o_status   <= (cmd == CMD_MESSAGE) && (n_col >= rows_eff);
                        unique case (cmd)
                            CMD_LOAD_TAP: begin
                                if (32'(i_tap_index) < MAX_WEIGHT) begin
                                    r_tap_start[TAP_W'(i_tap_index)] <= i_position;
                                    r_red_ok[TAP_W'(i_tap_index)]    <= 1'b0;
                                end
                            end
                            CMD_WRITE: begin
                            end
                            CMD_READ: begin
                                r_pos_ok <= pos_in_range;
                                r_state  <= S_READ;
                            end
                            CMD_MESSAGE: begin
                                if (n_col >= rows_eff) begin
                                    r_col <= n_col;
                                end else if (!i_bit_value) begin
                                    r_col <= n_col + 1'b1;
                                end else begin
                                    r_col_cur <= n_col;
                                    r_col     <= n_col;
                                    if (r_red_rows != rows_eff) begin
                                        r_red_ok   <= '0;
                                        r_red_rows <= rows_eff;
                                    end
                                    r_state <= S_RED;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    o_read_bit <= r_rdata && r_pos_ok;
                    r_state    <= S_IDLE;
                end
                S_RED: begin
                    if (pend_any) begin
                        r_div_tap <= pend_first;
                        r_state   <= S_DIV;
                    end else begin
                        r_j     <= '0;
                        r_p_vld <= 1'b0;
                        r_state <= S_TAPS;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_tap_red[r_div_tap] <= div_rem;
                        r_red_ok[r_div_tap]  <= 1'b1;
                        r_state              <= S_RED;
                    end
                end
                S_TAPS: begin
                    r_p_vld  <= issue;
                    r_p_addr <= n_row;
                    if (issue) begin
                        r_j <= r_j + 1'b1;
                    end else if (!r_p_vld) begin
                        r_col   <= r_col_cur + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
